>>> hdl/four_channel_counter_timer_core_defines.svh
// Assertion macros for the four-channel counter/timer checker.
// No dependencies; included by the checker file only.
`ifndef FOUR_CHANNEL_COUNTER_TIMER_CORE_DEFINES_SVH
`define FOUR_CHANNEL_COUNTER_TIMER_CORE_DEFINES_SVH

// same-cycle implication
`define FCCT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error("check failed");

// next-cycle implication
`define FCCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error("check failed");

`endif

>>> hdl/fcct_pkg.sv
// Shared types and constants for the four-channel counter/timer.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package fcct_pkg;

    localparam logic [2:0] FN_WRITE = 3'd0;
    localparam logic [2:0] FN_READ  = 3'd1;
    localparam logic [2:0] FN_TICK  = 3'd2;
    localparam logic [2:0] FN_PULSE = 3'd3;
    localparam logic [2:0] FN_RETI  = 3'd4;
    localparam logic [2:0] FN_POLL  = 3'd5;

    localparam logic [7:0] CTL_IRQ      = 8'h80;
    localparam logic [7:0] CTL_COUNTER  = 8'h40;
    localparam logic [7:0] CTL_PRESCALE = 8'h20;
    localparam logic [7:0] CTL_TRIGGER  = 8'h08;
    localparam logic [7:0] CTL_TCONST   = 8'h04;
    localparam logic [7:0] CTL_RESET    = 8'h02;
    localparam logic [7:0] CTL_CONTROL  = 8'h01;
    localparam logic [7:0] VEC_MASK     = 8'hF8;

    localparam int NCH = 4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_WRITE,
        OP_READ,
        OP_PULSE,
        OP_PULSE1,
        OP_TLOAD,
        OP_TWRAP,
        OP_TSTORE,
        OP_RETI,
        OP_POLL,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] tch;
    } t_cmd;

    typedef struct packed {
        logic chain;
        logic neg;
    } t_stat;

endpackage
`default_nettype wire

>>> hdl/four_channel_counter_timer_core.sv
// Top level of the four-channel counter/timer with vectored interrupt chain.
// Depends on fcct_pkg, fcct_ctrl and fcct_dp.
// An item is taken when start is high and busy low; each item yields one result,
// shown for one cycle with o_done, and the receiver cannot stall it. Writes, reads,
// polls and returns pass through the execute state; a pulse that chains from
// channel 0 into channel 1 adds the S_PULSE1 state; a tick walks the four
// channels in turn, a load-and-subtract state per channel then a wrap state that
// adds the reload once per counter wrap (a wrap of channel 0 pulses channel 1).
`timescale 1ns / 1ps
`default_nettype none
module four_channel_counter_timer_core
    import fcct_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_func,
    input  wire logic [1:0] i_channel,
    input  wire logic [7:0] i_data,
    input  wire logic [7:0] i_tick_clocks,
    output logic            o_done,
    output logic [7:0]      o_read_data,
    output logic            o_irq_raise,
    output logic [7:0]      o_irq_vector,
    output logic [3:0]      o_pending_mask,
    output logic [2:0]      o_live_source
);

    t_cmd  cmd;
    t_stat stat;

    fcct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    fcct_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_channel      (i_channel),
        .i_data         (i_data),
        .i_tick_clocks  (i_tick_clocks),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_read_data    (o_read_data),
        .o_irq_raise    (o_irq_raise),
        .o_irq_vector   (o_irq_vector),
        .o_pending_mask (o_pending_mask),
        .o_live_source  (o_live_source)
    );

endmodule
`default_nettype wire

>>> hdl/fcct_ctrl.sv
// Sequencer for the counter/timer: decodes each item into datapath commands.
// Depends on fcct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcct_ctrl
    import fcct_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [2:0] i_func,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd,
    output logic            busy
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_PULSE1 = 6'b000100,
        S_TLOAD  = 6'b001000,
        S_TWRAP  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_func, n_func;
    logic [1:0] r_tch, n_tch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func  <= FN_WRITE;
            r_tch   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
            r_tch   <= n_tch;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_tch      = r_tch;
        o_cmd.op   = OP_NONE;
        o_cmd.tch  = r_tch;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_CAPTURE;
                    n_func   = i_func;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_func)
                    FN_WRITE: o_cmd.op = OP_WRITE;
                    FN_READ:  o_cmd.op = OP_READ;
                    FN_TICK: begin
                        n_tch   = 2'd0;
                        n_state = S_TLOAD;
                    end
                    FN_PULSE: begin
                        o_cmd.op = OP_PULSE;
                        if (i_stat.chain) begin
                            n_state = S_PULSE1;
                        end
                    end
                    FN_RETI:  o_cmd.op = OP_RETI;
                    FN_POLL:  o_cmd.op = OP_POLL;
                    default:  o_cmd.op = OP_NONE;
                endcase
            end
            S_PULSE1: begin
                o_cmd.op = OP_PULSE1;
                n_state  = S_DONE;
            end
            S_TLOAD: begin
                o_cmd.op = OP_TLOAD;
                n_state  = S_TWRAP;
            end
            S_TWRAP: begin
                if (i_stat.neg) begin
                    o_cmd.op = OP_TWRAP;
                end else begin
                    o_cmd.op = OP_TSTORE;
                    if (r_tch == 2'(NCH - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_tch   = r_tch + 2'd1;
                        n_state = S_TLOAD;
                    end
                end
            end
            S_DONE: begin
                o_cmd.op = OP_DONE;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

>>> hdl/fcct_dp.sv
// Datapath for the counter/timer: channel registers, interrupt chain, results.
// Depends on fcct_pkg; driven by fcct_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module fcct_dp
    import fcct_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic [1:0] i_channel,
    input  wire logic [7:0] i_data,
    input  wire logic [7:0] i_tick_clocks,
    output t_stat           o_stat,
    output logic            o_done,
    output logic [7:0]      o_read_data,
    output logic            o_irq_raise,
    output logic [7:0]      o_irq_vector,
    output logic [3:0]      o_pending_mask,
    output logic [2:0]      o_live_source
);

    logic [15:0] r_cnt [NCH];
    logic [7:0]  r_rel [NCH];
    logic [7:0]  r_ctl [NCH];
    logic [15:0] n_cnt [NCH];
    logic [7:0]  n_rel [NCH];
    logic [7:0]  n_ctl [NCH];
    logic [7:0]  r_vb, n_vb;
    logic [3:0]  r_pend, n_pend;
    logic [2:0]  r_live, n_live;
    logic [1:0]  r_ch, n_ch;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_clk, n_clk;
    logic [16:0] r_n, n_n;
    logic        r_act, n_act;
    logic [7:0]  r_rd, n_rd;
    logic        r_raise, n_raise;
    logic [7:0]  r_vec, n_vec;

    logic [1:0]  p_sel;
    logic [15:0] pl_cnt;
    logic [7:0]  pl_ctl;
    logic        pl_flag, pl_chain;

    logic [1:0]  t;
    logic [11:0] dec;
    logic [3:0]  pp;
    logic        pfound;
    logic [1:0]  psel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_cnt[i] <= '0;
                r_rel[i] <= '0;
                r_ctl[i] <= CTL_RESET;
            end
            r_vb   <= '0;
            r_pend <= '0;
            r_live <= '0;
            o_done <= 1'b0;
        end else begin
            for (int i = 0; i < NCH; i++) begin
                r_cnt[i] <= n_cnt[i];
                r_rel[i] <= n_rel[i];
                r_ctl[i] <= n_ctl[i];
            end
            r_vb   <= n_vb;
            r_pend <= n_pend;
            r_live <= n_live;
            o_done <= (i_cmd.op == OP_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch    <= n_ch;
        r_data  <= n_data;
        r_clk   <= n_clk;
        r_n     <= n_n;
        r_act   <= n_act;
        r_rd    <= n_rd;
        r_raise <= n_raise;
        r_vec   <= n_vec;
        if (i_cmd.op == OP_DONE) begin
            o_read_data    <= r_rd;
            o_irq_raise    <= r_raise;
            o_irq_vector   <= r_raise ? r_vec : 8'h00;
            o_pending_mask <= r_pend;
            o_live_source  <= r_live;
        end
    end

    // pulse into one channel
    assign p_sel = (i_cmd.op == OP_PULSE) ? r_ch : 2'd1;

    always_comb begin
        pl_cnt   = r_cnt[p_sel];
        pl_ctl   = r_ctl[p_sel];
        pl_flag  = 1'b0;
        pl_chain = 1'b0;
        if ((pl_ctl & CTL_COUNTER) != 8'h00) begin
            if ((pl_ctl & (CTL_TCONST | CTL_RESET)) != (CTL_TCONST | CTL_RESET)) begin
                if (pl_cnt >= 16'h0100) begin
                    pl_cnt = pl_cnt - 16'h0100;
                end
                if (pl_cnt[15:8] == 8'h00) begin
                    pl_flag  = ((pl_ctl & CTL_IRQ) != 8'h00);
                    pl_chain = (p_sel == 2'd0);
                    pl_cnt   = {r_rel[p_sel], 8'h00};
                end
            end
        end else begin
            pl_ctl = pl_ctl & ~CTL_TRIGGER;
        end
    end

    assign o_stat.chain = pl_chain;
    assign o_stat.neg   = r_n[16];
    assign t            = i_cmd.tch;
    assign dec = ((r_ctl[t] & CTL_PRESCALE) != 8'h00) ? {4'h0, r_clk} : {r_clk, 4'h0};

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            n_cnt[i] = r_cnt[i];
            n_rel[i] = r_rel[i];
            n_ctl[i] = r_ctl[i];
        end
        n_vb    = r_vb;
        n_pend  = r_pend;
        n_live  = r_live;
        n_ch    = r_ch;
        n_data  = r_data;
        n_clk   = r_clk;
        n_n     = r_n;
        n_act   = r_act;
        n_rd    = r_rd;
        n_raise = r_raise;
        n_vec   = r_vec;
        pp      = r_pend;
        case (i_cmd.op)
            OP_CAPTURE: begin
                n_ch    = i_channel;
                n_data  = i_data;
                n_clk   = i_tick_clocks;
                n_n     = '0;
                n_rd    = '0;
                n_raise = 1'b0;
                n_vec   = '0;
            end
            OP_WRITE: begin
                if ((r_ctl[r_ch] & CTL_TCONST) != 8'h00) begin
                    n_rel[r_ch] = r_data;
                    if ((r_ctl[r_ch] & CTL_RESET) != 8'h00) begin
                        n_cnt[r_ch] = {r_data - 8'd1, 8'h00};
                    end
                    n_ctl[r_ch] = r_ctl[r_ch] & ~CTL_TCONST;
                end else if ((r_data & CTL_CONTROL) != 8'h00) begin
                    n_ctl[r_ch] = r_data;
                    if ((r_data & (CTL_TCONST | CTL_RESET)) == CTL_RESET) begin
                        n_cnt[r_ch] = {r_rel[r_ch] - 8'd1, 8'h00};
                    end
                    if (((r_data & CTL_IRQ) == 8'h00) && r_pend[r_ch]) begin
                        n_pend[r_ch] = 1'b0;
                        if ((n_pend == 4'h0) && (r_live == {1'b0, r_ch} + 3'd1)) begin
                            n_live = '0;
                        end
                    end
                end else if (r_ch == 2'd0) begin
                    n_vb = r_data;
                end
            end
            OP_READ: n_rd = r_cnt[r_ch][15:8];
            OP_PULSE, OP_PULSE1: begin
                n_cnt[p_sel] = pl_cnt;
                n_ctl[p_sel] = pl_ctl;
                if (pl_flag) begin
                    n_pend[p_sel] = 1'b1;
                end
            end
            OP_TLOAD: begin
                n_act = ((r_ctl[t] & (CTL_TCONST | CTL_RESET)) != (CTL_TCONST | CTL_RESET))
                        && ((r_ctl[t] & CTL_COUNTER) == 8'h00);
                n_n   = n_act ? ({1'b0, r_cnt[t]} - {5'h00, dec}) : 17'h0;
            end
            OP_TWRAP: begin
                if ((r_ctl[t] & CTL_IRQ) != 8'h00) begin
                    n_pend[t] = 1'b1;
                end
                n_n = r_n + {(r_rel[t] == 8'h00), r_rel[t], 8'h00};
                if (t == 2'd0) begin
                    n_cnt[1] = pl_cnt;
                    n_ctl[1] = pl_ctl;
                    if (pl_flag) begin
                        n_pend[1] = 1'b1;
                    end
                end
            end
            OP_TSTORE: begin
                if (r_act) begin
                    n_cnt[t] = r_n[15:0];
                end
            end
            OP_RETI: begin
                if (r_live != 3'd0) begin
                    pp = r_pend & ~(4'h1 << r_live[1:0] - 2'd1);
                end
                n_pend = pp;
                n_live = '0;
                if (pfound) begin
                    n_raise = 1'b1;
                    n_vec   = (r_vb & VEC_MASK) + {5'h00, psel, 1'b0};
                    n_live  = {1'b0, psel} + 3'd1;
                end
            end
            OP_POLL: begin
                if ((r_live == 3'd0) && pfound) begin
                    n_raise = 1'b1;
                    n_vec   = (r_vb & VEC_MASK) + {5'h00, psel, 1'b0};
                    n_live  = {1'b0, psel} + 3'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // lowest pending channel
    always_comb begin
        pfound = 1'b0;
        psel   = 2'd0;
        for (int k = NCH - 1; k >= 0; k--) begin
            if (pp[k]) begin
                pfound = 1'b1;
                psel   = 2'(k);
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/fcct_checker.sv
// Port-level checks for the counter/timer, bound to the top level.
// Depends on four_channel_counter_timer_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "four_channel_counter_timer_core_defines.svh"
module fcct_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic       o_irq_raise,
    input wire logic [7:0] o_irq_vector,
    input wire logic [2:0] o_live_source
);

    `FCCT_ASSERT_NEXT(a_take, i_clk, i_rst_n, start && !busy, busy)
    `FCCT_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `FCCT_ASSERT_NOW(a_raise_live, i_clk, i_rst_n, o_done && o_irq_raise, o_live_source != 3'd0)
    `FCCT_ASSERT_NOW(a_vec_zero, i_clk, i_rst_n, o_done && !o_irq_raise, o_irq_vector == 8'h00)

endmodule

bind four_channel_counter_timer_core fcct_checker u_fcct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_irq_raise   (o_irq_raise),
    .o_irq_vector  (o_irq_vector),
    .o_live_source (o_live_source)
);
`default_nettype wire
